@@ sv/pnf_pkg.sv @@
// ----------------------------------------------------------------------------
// pnf_pkg: shared types and constants of the gradient noise sampler
// corner hash multipliers, output scale and offset tables, pipeline context
// ----------------------------------------------------------------------------
`default_nettype none

package pnf_pkg;

  localparam int CoordW  = 32;
  localparam int FracW   = 16;
  localparam int CellW   = 17;
  localparam int HashW   = 32;
  localparam int CvalW   = 20;
  localparam int WeightW = 14;
  localparam int NoiseW  = 16;
  localparam int Axes    = 3;
  localparam int Corners = 8;

  localparam logic [HashW-1:0] AxisMul [Axes] = '{32'h27D4EB2D, 32'hB5297A4D, 32'h1B56C4E9};
  localparam logic [HashW-1:0] MixMul = 32'h92C3412B;

  typedef enum logic [2:0] {
    KIND_1D_W16,
    KIND_2D_W16,
    KIND_3D_W16,
    KIND_1D_W8,
    KIND_2D_W8,
    KIND_3D_W8
  } kind_t;

  // per-beat control that travels with the data
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [1:0] dims;
    logic       narrow;
  } ctx_t;

  function automatic logic [1:0] dims_of(kind_t k);
    unique case (k)
      KIND_2D_W16, KIND_2D_W8: dims_of = 2'd2;
      KIND_3D_W16, KIND_3D_W8: dims_of = 2'd3;
      default:                 dims_of = 2'd1;
    endcase
  endfunction

  function automatic logic [11:0] out_scale(kind_t k);
    unique case (k)
      KIND_1D_W16: out_scale = 12'd1159;
      KIND_2D_W16: out_scale = 12'd1537;
      KIND_3D_W16: out_scale = 12'd1731;
      KIND_1D_W8:  out_scale = 12'd1353;
      KIND_2D_W8:  out_scale = 12'd1620;
      KIND_3D_W8:  out_scale = 12'd2015;
      default:     out_scale = 12'd0;
    endcase
  endfunction

  function automatic logic [15:0] out_offset(kind_t k);
    unique case (k)
      KIND_1D_W16: out_offset = 16'd32803;
      KIND_2D_W16: out_offset = 16'd32725;
      KIND_3D_W16: out_offset = 16'd33147;
      KIND_1D_W8:  out_offset = 16'd32769;
      KIND_2D_W8:  out_offset = 16'd32771;
      KIND_3D_W8:  out_offset = 16'd33168;
      default:     out_offset = 16'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ sv/pnf_front.sv @@
// ----------------------------------------------------------------------------
// pnf_front: lattice decode, corner hashing and corner gradient values
// three register stages: axis products, hash mix, gradient times offset
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  pnf_pkg::ctx_t                          ctx_i,
  input  logic        [pnf_pkg::CoordW-1:0]      coord_i [pnf_pkg::Axes],
  output pnf_pkg::ctx_t                          ctx_o,
  output logic signed [pnf_pkg::CvalW-1:0]       cval_o  [pnf_pkg::Corners],
  output logic        [pnf_pkg::WeightW-1:0]     w_o     [pnf_pkg::Axes]
);
  import pnf_pkg::*;

  // grad in -2..1 times signed offset, -2 times -65536 needs 19 bits
  function automatic logic signed [19:0] gmul(logic [1:0] g, logic signed [16:0] off);
    logic signed [19:0] x;
    x = 20'(off);
    unique case (g)
      2'd0: gmul = -(x <<< 1);
      2'd1: gmul = -x;
      2'd2: gmul = '0;
      2'd3: gmul = x;
    endcase
  endfunction

  logic [CellW-1:0] lo_c   [Axes];
  logic [CellW-1:0] hi_c   [Axes];
  logic [FracW-1:0] frac_c [Axes];
  logic [HashW-1:0] plo_c  [Axes];
  logic [HashW-1:0] phi_c  [Axes];
  logic [FracW-1:0] sq_c   [Axes];

  ctx_t             ctx1_r;
  logic [HashW-1:0] plo_r  [Axes];
  logic [HashW-1:0] phi_r  [Axes];
  logic [FracW-1:0] frac1_r[Axes];
  logic [FracW-1:0] sq1_r  [Axes];

  // stage 1: cell corners, fraction, axis products, fraction squared
  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      if (ctx_i.narrow) begin
        lo_c[i]   = CellW'(coord_i[i][15:8]);
        hi_c[i]   = CellW'(8'(coord_i[i][15:8] + 8'd1));
        frac_c[i] = {coord_i[i][7:0], 8'h00};
      end else begin
        lo_c[i]   = CellW'(coord_i[i][31:16]);
        hi_c[i]   = CellW'(coord_i[i][31:16]) + CellW'(1);
        frac_c[i] = coord_i[i][15:0];
      end
      plo_c[i] = HashW'(HashW'(lo_c[i]) * AxisMul[i]);
      phi_c[i] = HashW'(HashW'(hi_c[i]) * AxisMul[i]);
      sq_c[i]  = FracW'((32'(frac_c[i]) * 32'(frac_c[i])) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx1_r.valid <= 1'b0;
    end else if (en) begin
      ctx1_r.valid <= ctx_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r.kind   <= ctx_i.kind;
      ctx1_r.dims   <= ctx_i.dims;
      ctx1_r.narrow <= ctx_i.narrow;
      plo_r         <= plo_c;
      phi_r         <= phi_c;
      frac1_r       <= frac_c;
      sq1_r         <= sq_c;
    end
  end

  logic [HashW-1:0]   hm_c   [Corners];
  logic [WeightW-1:0] w_c    [Axes];
  ctx_t               ctx2_r;
  logic [HashW-1:0]   hm_r   [Corners];
  logic [WeightW-1:0] w2_r   [Axes];
  logic [FracW-1:0]   frac2_r[Axes];

  // stage 2: corner hash mix and smoothstep weight
  always_comb begin
    logic [HashW-1:0] h;
    logic [2:0]       cb;
    logic [31:0]      f;
    logic [31:0]      wp;
    for (int c = 0; c < Corners; c++) begin
      cb = 3'(c);
      h  = '0;
      for (int i = 0; i < Axes; i++) begin
        if (2'(i) < ctx1_r.dims) begin
          h = h ^ (cb[i] ? phi_r[i] : plo_r[i]);
        end
      end
      h = h ^ (h >> 15);
      hm_c[c] = HashW'(h * MixMul);
    end
    for (int i = 0; i < Axes; i++) begin
      f      = 32'd196608 - (32'(frac1_r[i]) << 1);
      wp     = 32'(32'(sq1_r[i]) * f);
      w_c[i] = wp[31:18];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx2_r.valid <= 1'b0;
    end else if (en) begin
      ctx2_r.valid <= ctx1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r.kind   <= ctx1_r.kind;
      ctx2_r.dims   <= ctx1_r.dims;
      ctx2_r.narrow <= ctx1_r.narrow;
      hm_r          <= hm_c;
      w2_r          <= w_c;
      frac2_r       <= frac1_r;
    end
  end

  logic signed [CvalW-1:0] cv_c  [Corners];
  ctx_t                    ctx3_r;
  logic signed [CvalW-1:0] cval_r[Corners];
  logic [WeightW-1:0]      w3_r  [Axes];

  // stage 3: gradients times offsets, per dimension count
  always_comb begin
    logic [HashW-1:0]   h;
    logic [2:0]         cb;
    logic signed [16:0] off0, off1, off2;
    logic signed [19:0] t0;
    logic signed [20:0] s2;
    logic signed [20:0] s3;
    logic signed [27:0] p85;
    for (int c = 0; c < Corners; c++) begin
      cb = 3'(c);
      h  = hm_r[c] ^ (hm_r[c] >> 13);
      if (ctx2_r.dims == 2'd1) begin
        h = h ^ (h >> 7);
      end
      // upper corner offset is fraction minus one cell
      off0 = $signed({cb[0], frac2_r[0]});
      off1 = $signed({cb[1], frac2_r[1]});
      off2 = $signed({cb[2], frac2_r[2]});
      t0   = gmul(h[1:0], off0);
      s2   = 21'(t0) + 21'(gmul(h[2:1], off1));
      s3   = 21'(t0) + 21'(gmul(h[3:2], off1)) + 21'(gmul(h[4:3], off2));
      p85  = 28'(s3) * 28'sd85;
      unique case (ctx2_r.dims)
        2'd1:    cv_c[c] = CvalW'(t0 >>> 1);
        2'd2:    cv_c[c] = CvalW'(s2 >>> 2);
        default: cv_c[c] = CvalW'(p85 >>> 9);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx3_r.valid <= 1'b0;
    end else if (en) begin
      ctx3_r.valid <= ctx2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r.kind   <= ctx2_r.kind;
      ctx3_r.dims   <= ctx2_r.dims;
      ctx3_r.narrow <= ctx2_r.narrow;
      cval_r        <= cv_c;
      w3_r          <= w2_r;
    end
  end

  assign ctx_o  = ctx3_r;
  assign cval_o = cval_r;
  assign w_o    = w3_r;

endmodule

`default_nettype wire

@@ sv/pnf_blend.sv @@
// ----------------------------------------------------------------------------
// pnf_blend: corner blending along x, y, z and output scaling
// four register stages, the last one is the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  pnf_pkg::ctx_t                      ctx_i,
  input  logic signed [pnf_pkg::CvalW-1:0]   cval_i [pnf_pkg::Corners],
  input  logic        [pnf_pkg::WeightW-1:0] w_i    [pnf_pkg::Axes],
  output pnf_pkg::ctx_t                      ctx_o,
  output logic        [pnf_pkg::NoiseW-1:0]  noise_o
);
  import pnf_pkg::*;

  localparam int DiffW = CvalW + 1;
  localparam int ProdW = DiffW + WeightW + 1;

  // a + floor((b - a) * t / 2^14)
  function automatic logic signed [CvalW-1:0] lerp(logic signed [CvalW-1:0] a,
                                                   logic signed [CvalW-1:0] b,
                                                   logic [WeightW-1:0] t);
    logic signed [DiffW-1:0] d;
    logic signed [ProdW-1:0] p;
    d    = DiffW'(b) - DiffW'(a);
    p    = ProdW'(d) * $signed({1'b0, t});
    lerp = CvalW'(ProdW'(a) + (p >>> WeightW));
  endfunction

  ctx_t                    ctx4_r, ctx5_r, ctx6_r, ctx7_r;
  logic signed [CvalW-1:0] v4_r [4];
  logic signed [CvalW-1:0] v5_r [2];
  logic signed [CvalW-1:0] v6_r;
  logic [WeightW-1:0]      w4_r [2];
  logic [WeightW-1:0]      w5_r;
  logic [NoiseW-1:0]       noise_r;

  logic signed [CvalW-1:0] v4_nxt [4];
  logic signed [CvalW-1:0] v5_nxt [2];
  logic signed [CvalW-1:0] v6_nxt;
  logic [NoiseW-1:0]       noise_nxt;

  // x blend, always used
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      v4_nxt[j] = lerp(cval_i[2*j], cval_i[2*j+1], w_i[0]);
    end
  end

  // y blend for 2d and 3d
  always_comb begin
    if (ctx4_r.dims >= 2'd2) begin
      v5_nxt[0] = lerp(v4_r[0], v4_r[1], w4_r[0]);
      v5_nxt[1] = lerp(v4_r[2], v4_r[3], w4_r[0]);
    end else begin
      v5_nxt[0] = v4_r[0];
      v5_nxt[1] = v4_r[1];
    end
  end

  // z blend for 3d
  always_comb begin
    if (ctx5_r.dims == 2'd3) begin
      v6_nxt = lerp(v5_r[0], v5_r[1], w5_r);
    end else begin
      v6_nxt = v5_r[0];
    end
  end

  // scale, offset and wrap to result width, zero for unused kinds
  always_comb begin
    logic signed [32:0] prod;
    logic signed [22:0] s;
    prod = 33'(v6_r) * $signed({1'b0, out_scale(ctx6_r.kind)});
    s    = 23'(prod >>> 10) + $signed({7'b0, out_offset(ctx6_r.kind)});
    if (ctx6_r.kind > KIND_3D_W8) begin
      noise_nxt = '0;
    end else if (ctx6_r.narrow) begin
      noise_nxt = {8'h00, s[15:8]};
    end else begin
      noise_nxt = s[15:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx4_r.valid <= 1'b0;
      ctx5_r.valid <= 1'b0;
      ctx6_r.valid <= 1'b0;
      ctx7_r.valid <= 1'b0;
    end else if (en) begin
      ctx4_r.valid <= ctx_i.valid;
      ctx5_r.valid <= ctx4_r.valid;
      ctx6_r.valid <= ctx5_r.valid;
      ctx7_r.valid <= ctx6_r.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r.kind   <= ctx_i.kind;
      ctx4_r.dims   <= ctx_i.dims;
      ctx4_r.narrow <= ctx_i.narrow;
      ctx5_r.kind   <= ctx4_r.kind;
      ctx5_r.dims   <= ctx4_r.dims;
      ctx5_r.narrow <= ctx4_r.narrow;
      ctx6_r.kind   <= ctx5_r.kind;
      ctx6_r.dims   <= ctx5_r.dims;
      ctx6_r.narrow <= ctx5_r.narrow;
      ctx7_r.kind   <= ctx6_r.kind;
      ctx7_r.dims   <= ctx6_r.dims;
      ctx7_r.narrow <= ctx6_r.narrow;
      v4_r          <= v4_nxt;
      w4_r[0]       <= w_i[1];
      w4_r[1]       <= w_i[2];
      v5_r          <= v5_nxt;
      w5_r          <= w4_r[1];
      v6_r          <= v6_nxt;
      noise_r       <= noise_nxt;
    end
  end

  assign ctx_o   = ctx7_r;
  assign noise_o = noise_r;

endmodule

`default_nettype wire

@@ sv/perlin_noise_fixed_point.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_fixed_point: fixed-point gradient noise sampler, 1d/2d/3d
// seven-stage pipeline from coordinates to one noise sample per beat
// ----------------------------------------------------------------------------
// throughput: one beat per cycle; the whole pipeline holds while out_tready
//   is low and a result is waiting
// reset: synchronous active-low rst_n clears all stage valid bits
`default_nettype none

module perlin_noise_fixed_point (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // noise_value[15:0]
);
  import pnf_pkg::*;

  logic                    en;
  ctx_t                    ctx0;
  ctx_t                    ctx3;
  ctx_t                    ctx7;
  logic [CoordW-1:0]       coord  [Axes];
  logic signed [CvalW-1:0] cval   [Corners];
  logic [WeightW-1:0]      weight [Axes];
  logic [NoiseW-1:0]       noise;

  // pipeline advances unless the output register holds an untaken result
  assign en        = !ctx7.valid || out_tready;
  assign in_tready = en;

  // input beat decode
  always_comb begin
    ctx0.valid  = in_tvalid;
    ctx0.kind   = kind_t'(in_tuser);
    ctx0.dims   = dims_of(kind_t'(in_tuser));
    ctx0.narrow = kind_t'(in_tuser) >= KIND_1D_W8;
    coord[0]    = in_tdata[31:0];
    coord[1]    = in_tdata[63:32];
    coord[2]    = in_tdata[95:64];
  end

  pnf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctx_i   (ctx0),
    .coord_i (coord),
    .ctx_o   (ctx3),
    .cval_o  (cval),
    .w_o     (weight)
  );

  pnf_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctx_i   (ctx3),
    .cval_i  (cval),
    .w_i     (weight),
    .ctx_o   (ctx7),
    .noise_o (noise)
  );

  assign out_tvalid = ctx7.valid;
  assign out_tdata  = noise;

  // 8-bit modes leave the upper byte clear
  a_small_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctx7.valid && ctx7.narrow |-> out_tdata[15:8] == 8'h00)
    else $error("8-bit mode result has upper byte set");

  // unused kinds give zero
  a_bad_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctx7.valid && ctx7.kind > KIND_3D_W8 |-> out_tdata == '0)
    else $error("unused kind gave nonzero result");

  // a held output stalls the middle of the pipeline too
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctx7.valid && !out_tready |=> $stable(ctx3.valid))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
